// ===== rtl/core/md5_pkg.sv =====
// MD5 engine package: item structs, chaining-word struct, round tables
// and small helper functions. No dependencies.
package md5_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_first;
        logic [63:0] digest_second;
    } t_out_item;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_words;

    localparam int WORD_DEPTH = 16;
    localparam int WORD_AW    = 4;

    localparam t_words IV = '{
        a: 32'h67452301,
        b: 32'hefcdab89,
        c: 32'h98badcfe,
        d: 32'h10325476
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // message word used by a round; only r mod 16 matters inside a group
    function automatic logic [3:0] msg_idx(input logic [5:0] rnd);
        logic [3:0] r;
        logic [3:0] idx;
        r = rnd[3:0];
        case (rnd[5:4])
            2'd0:    idx = r;
            2'd1:    idx = 4'((r << 2) + r + 4'd1);
            2'd2:    idx = 4'((r << 1) + r + 4'd5);
            default: idx = 4'((r << 3) - r);
        endcase
        return idx;
    endfunction

    function automatic logic [31:0] bswap(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

// ===== rtl/core/md5_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/md5_round.sv =====
// MD5 round unit: holds the working words a..d and applies one round per step.
// Depends on md5_pkg (t_words, ROUND_K, ROT_AMT).
module md5_round (
    input  logic               i_clk,
    input  logic               i_load,
    input  logic               i_step,
    input  logic [5:0]         i_rnd,
    input  logic [31:0]        i_w,
    input  md5_pkg::t_words    i_init,
    output md5_pkg::t_words    o_words
);

    md5_pkg::t_words r_words;
    md5_pkg::t_words n_words;

    logic [31:0] fn;
    logic [31:0] sum;
    logic [63:0] dbl;
    logic [4:0]  amt;

    always_comb begin
        case (i_rnd[5:4])
            2'd0:    fn = (r_words.b & r_words.c) | (~r_words.b & r_words.d);
            2'd1:    fn = (r_words.b & r_words.d) | (r_words.c & ~r_words.d);
            2'd2:    fn = r_words.b ^ r_words.c ^ r_words.d;
            default: fn = r_words.c ^ (r_words.b | ~r_words.d);
        endcase
        sum = r_words.a + fn + i_w + md5_pkg::ROUND_K[i_rnd];
        amt = md5_pkg::ROT_AMT[{i_rnd[5:4], i_rnd[1:0]}];
        // rotate left: upper half of the doubled word shifted left
        dbl = {sum, sum} << amt;

        n_words = r_words;
        if (i_load) begin
            n_words = i_init;
        end else if (i_step) begin
            n_words.a = r_words.d;
            n_words.d = r_words.c;
            n_words.c = r_words.b;
            n_words.b = r_words.b + dbl[63:32];
        end
    end

    always_ff @(posedge i_clk) begin
        r_words <= n_words;
    end

    assign o_words = r_words;

endmodule

// ===== rtl/core/md5_hash_engine.sv =====
// MD5 engine top level: byte collector, padding sequencer, round control, digest output.
// A byte is taken while idle; every 64th byte starts a compression (load, 64 rounds in the
// shared round unit, fold), and no new byte is taken until that block is through.
// Final item: padding (up to 16 word writes, then a step to load) and one
// compression, twice when the last block has 56 or more bytes; then the digest is registered.
// Reset (synchronous, active low) restores the initial value words and a zero byte count.
module md5_hash_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  md5_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output md5_pkg::t_out_item o_result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_COMP = 3'd2;
    localparam logic [2:0] S_FOLD = 3'd3;
    localparam logic [2:0] S_PAD  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]          r_state,     n_state;
    logic [63:0]         r_cnt,       n_cnt;
    logic [31:0]         r_word,      n_word;
    md5_pkg::t_words     r_chain,     n_chain;
    logic [5:0]          r_rnd,       n_rnd;
    logic [4:0]          r_wp,        n_wp;
    logic                r_pad_first, n_pad_first;
    logic                r_len_blk,   n_len_blk;
    logic                r_pad_busy,  n_pad_busy;
    logic                r_eom,       n_eom;
    logic                r_o_valid,   n_o_valid;
    md5_pkg::t_out_item  r_res,       n_res;

    logic                           ram_we;
    logic [md5_pkg::WORD_AW-1:0]    ram_waddr;
    logic [31:0]                    ram_wdata;
    logic [md5_pkg::WORD_AW-1:0]    ram_raddr;
    logic [31:0]                    ram_rdata;

    md5_pkg::t_words     words;
    logic                in_fire;
    logic [63:0]         cnt_inc;
    logic [63:0]         bits;
    logic [31:0]         pad_word;
    logic [1:0]          lane;
    logic [5:0]          rnd_next;

    md5_ram #(
        .WIDTH (32),
        .DEPTH (md5_pkg::WORD_DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    md5_round u_round (
        .i_clk   (i_clk),
        .i_load  (r_state == S_LOAD),
        .i_step  (r_state == S_COMP),
        .i_rnd   (r_rnd),
        .i_w     (ram_rdata),
        .i_init  (r_chain),
        .o_words (words)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign in_fire  = i_valid && o_ready;
    assign cnt_inc  = r_cnt + 64'd1;
    assign bits     = {r_cnt[60:0], 3'b000};
    assign lane     = r_cnt[1:0];
    assign rnd_next = r_rnd + 6'd1;

    // last partial word: bytes so far, then the pad mark, then zeros
    always_comb begin
        pad_word = '0;
        for (int j = 0; j < 4; j++) begin
            if (2'(j) < lane) begin
                pad_word[8*j +: 8] = r_word[8*j +: 8];
            end else if (2'(j) == lane) begin
                pad_word[8*j +: 8] = md5_pkg::PAD_MARK;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_word      = r_word;
        n_chain     = r_chain;
        n_rnd       = r_rnd;
        n_wp        = r_wp;
        n_pad_first = r_pad_first;
        n_len_blk   = r_len_blk;
        n_pad_busy  = r_pad_busy;
        n_eom       = r_eom;
        n_res       = r_res;
        n_o_valid   = r_o_valid && !i_ready;
        ram_we      = 1'b0;
        ram_waddr   = r_cnt[5:2];
        ram_wdata   = '0;
        ram_raddr   = md5_pkg::msg_idx(6'd0);

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_item.byte_valid) begin
                        for (int j = 0; j < 4; j++) begin
                            if (2'(j) == lane) begin
                                n_word[8*j +: 8] = i_item.data_byte;
                            end
                        end
                        if (lane == 2'd3) begin
                            ram_we    = 1'b1;
                            ram_wdata = {i_item.data_byte, r_word[23:0]};
                        end
                        n_cnt = cnt_inc;
                    end
                    if (i_item.byte_valid && r_cnt[5:0] == 6'h3f) begin
                        n_state    = S_LOAD;
                        n_eom      = i_item.end_of_message;
                        n_pad_busy = 1'b0;
                    end else if (i_item.end_of_message) begin
                        n_state     = S_PAD;
                        n_pad_first = 1'b1;
                        n_pad_busy  = 1'b1;
                        n_len_blk   = i_item.byte_valid ? (cnt_inc[5:3] != 3'h7)
                                                        : (r_cnt[5:3] != 3'h7);
                    end
                end
            end
            S_LOAD: begin
                ram_raddr = md5_pkg::msg_idx(6'd0);
                n_rnd     = '0;
                n_state   = S_COMP;
            end
            S_COMP: begin
                // fetch the word for the following round ahead of time, since the buffer read is registered
                ram_raddr = md5_pkg::msg_idx(rnd_next);
                n_rnd     = rnd_next;
                if (r_rnd == 6'd63) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                n_chain.a = r_chain.a + words.a;
                n_chain.b = r_chain.b + words.b;
                n_chain.c = r_chain.c + words.c;
                n_chain.d = r_chain.d + words.d;
                if (!r_pad_busy) begin
                    if (r_eom) begin
                        n_state     = S_PAD;
                        n_pad_first = 1'b1;
                        n_pad_busy  = 1'b1;
                        n_len_blk   = (r_cnt[5:3] != 3'h7);
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (!r_len_blk) begin
                    // second padding block: zeros then the length
                    n_state     = S_PAD;
                    n_pad_first = 1'b0;
                    n_len_blk   = 1'b1;
                    n_wp        = '0;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PAD: begin
                if (r_pad_first) begin
                    ram_we      = 1'b1;
                    ram_waddr   = r_cnt[5:2];
                    ram_wdata   = pad_word;
                    n_wp        = {1'b0, r_cnt[5:2]} + 5'd1;
                    n_pad_first = 1'b0;
                end else if (r_wp[4]) begin
                    n_state = S_LOAD;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wp[3:0];
                    if (r_len_blk && r_wp[3:0] == 4'd14) begin
                        ram_wdata = bits[31:0];
                    end else if (r_len_blk && r_wp[3:0] == 4'd15) begin
                        ram_wdata = bits[63:32];
                    end
                    n_wp = r_wp + 5'd1;
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_res.digest_first  = {md5_pkg::bswap(r_chain.a),
                                           md5_pkg::bswap(r_chain.b)};
                    n_res.digest_second = {md5_pkg::bswap(r_chain.c),
                                           md5_pkg::bswap(r_chain.d)};
                    n_o_valid  = 1'b1;
                    n_chain    = md5_pkg::IV;
                    n_cnt      = '0;
                    n_pad_busy = 1'b0;
                    n_eom      = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_chain     <= md5_pkg::IV;
            r_rnd       <= '0;
            r_wp        <= '0;
            r_pad_first <= 1'b0;
            r_len_blk   <= 1'b0;
            r_pad_busy  <= 1'b0;
            r_eom       <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_chain     <= n_chain;
            r_rnd       <= n_rnd;
            r_wp        <= n_wp;
            r_pad_first <= n_pad_first;
            r_len_blk   <= n_len_blk;
            r_pad_busy  <= n_pad_busy;
            r_eom       <= n_eom;
            r_o_valid   <= n_o_valid;
        end
        r_word <= n_word;
        r_res  <= n_res;
    end

    assign o_valid  = r_o_valid;
    assign o_result = r_res;

    // round counter only runs during compression
    a_rnd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_COMP) |-> (r_rnd == 6'd0))
        else $error("round counter nonzero outside compression");

    // block buffer is never written while rounds read it
    a_no_wr_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE || r_state == S_PAD))
        else $error("buffer write during compression");

    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= 5'd16)
        else $error("pad write pointer out of range");

    // digest hand-off restarts the message
    a_done_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_o_valid || i_ready))
        |=> (r_cnt == 64'd0 && r_o_valid && r_chain == md5_pkg::IV))
        else $error("digest hand-off did not restart the message");

endmodule
